[rtl/ile_pkg.sv]
// Shared types and constants for the indexed list engine.
// Used by ile_cell and indexed_list_engine_core; depends on nothing else.
package ile_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 6;

	// Stream payload widths, padded to whole bytes.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ     = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_INS_AT   = 3'd3,
		CMD_DELETE   = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Shift control broadcast to every cell of the row.
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

endpackage

[rtl/ile_cell.sv]
// One storage cell of the list row: holds a single element.
// Depends on ile_pkg for the control struct and widths.
module ile_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                          clk,
	input  ile_pkg::cell_ctrl_t           ctrl,
	input  logic [ile_pkg::VAL_W-1:0]     ins_value,
	input  logic [ile_pkg::VAL_W-1:0]     left_value,
	input  logic [ile_pkg::VAL_W-1:0]     right_value,
	output logic [ile_pkg::VAL_W-1:0]     elem
);

	localparam logic [ile_pkg::POS_W-1:0] MY_POS = ile_pkg::POS_W'(IDX);

	logic [ile_pkg::VAL_W-1:0] elem_q;

	// Insert: cells above the position take their lower neighbor, the cell at the
	// position takes the new value. Delete: cells at and above take the upper one.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (ctrl.pos == MY_POS) begin
				elem_q <= ins_value;
			end else if (ctrl.pos < MY_POS) begin
				elem_q <= left_value;
			end
		end else if (ctrl.del && (ctrl.pos <= MY_POS)) begin
			elem_q <= right_value;
		end
	end

	assign elem = elem_q;

endmodule

[rtl/indexed_list_engine_core.sv]
// Indexed list engine: ordered list of signed 32-bit values in a row of cells.
// The result is registered and valid in the cycle after the input transfer; one
// command per cycle is sustained while m_tready is high, since the whole row shifts as a command is taken.
// Reset clears the element count and the result valid flag; element storage and
// result data are not reset. Depends on ile_pkg and ile_cell.
module indexed_list_engine_core #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [5:0] position, [37:6] value, [39:38] zero
	input  logic [ile_pkg::S_TDATA_W-1:0]     s_tdata,
	// [2:0] command
	input  logic [ile_pkg::CMD_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] read_value, [33:32] status, [39:34] element_count
	output logic [ile_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [ile_pkg::CNT_W-1:0] CAP_CNT = ile_pkg::CNT_W'(CAPACITY);

	logic                          s_fire;
	ile_pkg::cmd_t                 cmd;
	logic [ile_pkg::POS_W-1:0]     pos;
	logic [ile_pkg::VAL_W-1:0]     val;

	logic [ile_pkg::CNT_W-1:0]     count_q;
	logic                          out_valid_q;
	logic [ile_pkg::VAL_W-1:0]     rd_q;
	ile_pkg::status_t              st_q;
	logic [ile_pkg::CNT_W-1:0]     cnt_res_q;

	logic [ile_pkg::VAL_W-1:0]     elem [CAPACITY];
	logic [ile_pkg::VAL_W-1:0]     left_v [CAPACITY];
	logic [ile_pkg::VAL_W-1:0]     right_v [CAPACITY];
	logic [ile_pkg::VAL_W-1:0]     elem_rd;

	logic [ile_pkg::VAL_W-1:0]     rd_d;
	ile_pkg::status_t              st_d;
	logic [ile_pkg::CNT_W-1:0]     cnt_d;
	logic [ile_pkg::POS_W-1:0]     ins_pos;
	logic                          is_ins;
	logic                          do_ins;
	logic                          do_del;
	ile_pkg::cell_ctrl_t           ctrl;

	assign cmd = ile_pkg::cmd_t'(s_tuser);
	assign pos = s_tdata[ile_pkg::POS_W-1:0];
	assign val = s_tdata[ile_pkg::POS_W +: ile_pkg::VAL_W];

	// The result register frees itself when the downstream side takes the transfer.
	assign s_tready = !out_valid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	assign elem_rd = elem[pos[IW-1:0]];

	always_comb begin
		rd_d    = '0;
		st_d    = ile_pkg::ST_OK;
		cnt_d   = count_q;
		ins_pos = pos;
		is_ins  = 1'b0;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		unique case (cmd)
			ile_pkg::CMD_READ: begin
				if (pos < count_q) begin
					rd_d = elem_rd;
				end else begin
					rd_d = '1;
					st_d = ile_pkg::ST_RANGE;
				end
			end
			ile_pkg::CMD_INS_HEAD: begin
				ins_pos = '0;
				is_ins  = 1'b1;
			end
			ile_pkg::CMD_INS_TAIL: begin
				ins_pos = count_q;
				is_ins  = 1'b1;
			end
			ile_pkg::CMD_INS_AT: begin
				is_ins = 1'b1;
			end
			ile_pkg::CMD_DELETE: begin
				if (pos < count_q) begin
					do_del = 1'b1;
					cnt_d  = count_q - 1'b1;
				end else begin
					st_d = ile_pkg::ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		// The range check on an insert takes precedence over the full check.
		if (is_ins) begin
			if (ins_pos > count_q) begin
				st_d = ile_pkg::ST_RANGE;
			end else if (count_q >= CAP_CNT) begin
				st_d = ile_pkg::ST_FULL;
			end else begin
				do_ins = 1'b1;
				cnt_d  = count_q + 1'b1;
			end
		end
	end

	assign ctrl.ins = s_fire && do_ins;
	assign ctrl.del = s_fire && do_del;
	assign ctrl.pos = ins_pos;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_row
		if (i == 0) begin : g_first
			assign left_v[i] = elem[i];
		end else begin : g_mid
			assign left_v[i] = elem[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v[i] = elem[i];
		end else begin : g_inner
			assign right_v[i] = elem[i+1];
		end
		ile_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.ins_value  (val),
			.left_value (left_v[i]),
			.right_value(right_v[i]),
			.elem       (elem[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				count_q     <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			rd_q      <= rd_d;
			st_q      <= st_d;
			cnt_res_q <= cnt_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {cnt_res_q, st_q, rd_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("element count exceeds capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (count_q == $past(count_q)) ||
			(count_q == $past(count_q) + 1'b1) ||
			(count_q == $past(count_q) - 1'b1))
		else $error("element count moved by more than one");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (st_d != ile_pkg::ST_OK)) |=> $stable(count_q))
		else $error("failed command changed the element count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cnt_res_q == count_q))
		else $error("pending result count disagrees with list count");

endmodule
